### hw/rtl/rect_to_polar_degrees_assert.svh
// Assertion macros shared by the rect_to_polar_degrees RTL.
// Both take a label, the clock, the reset, a condition and a consequence.
`ifndef RECT_TO_POLAR_DEGREES_ASSERT_SVH
`define RECT_TO_POLAR_DEGREES_ASSERT_SVH

`ifndef SYNTHESIS
// Consequence must hold in the same cycle as the condition.
`define RTPD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rect_to_polar_degrees: assertion failed");
// Consequence must hold in the cycle after the condition.
`define RTPD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rect_to_polar_degrees: assertion failed");
`else
`define RTPD_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define RTPD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

### hw/rtl/r2p_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package r2p_pkg;

   // Widths of the sample and result fields.
   localparam int DATA_WIDTH = 16;
   localparam int OUT_W      = 16;
   localparam int ITERATIONS = 16;

   // Internal fixed-point formats: x and y in Q16, angle in degrees Q16.
   localparam int FRAC_BITS = 16;
   localparam int XW        = DATA_WIDTH + FRAC_BITS + 3;
   localparam int ZW        = 26;
   localparam int IDX_W     = 5;

   // Gain correction constant 0.6072529350 in Q30.
   localparam int GAIN_W = 30;
   localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;
   localparam int PH_W = XW - FRAC_BITS + GAIN_W;

   // Angle output conversion from Q16 to Q7 with rounding.
   localparam int ANG_SHIFT = FRAC_BITS - 7;
   localparam int ANG_ROUND = 1 << (ANG_SHIFT - 1);
   localparam int DEG180_Q7 = 23040;
   localparam int DEG90_Q7  = 11520;
   localparam int DEG180_Q16 = 180 << FRAC_BITS;

   // Payload that travels along the rotation chain.
   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 special;
      logic [OUT_W-1:0]     spec_mag;
      logic [OUT_W-1:0]     spec_ang;
   } r2p_data_type;

   // Arctangent of 2^-i in degrees, Q16, rounded to nearest.
   function automatic logic signed [ZW-1:0] atan_q16(input logic [IDX_W-1:0] idx);
      logic signed [ZW-1:0] val;
      begin
         case (idx)
            5'd0:    val = ZW'(2949120);
            5'd1:    val = ZW'(1740967);
            5'd2:    val = ZW'(919879);
            5'd3:    val = ZW'(466945);
            5'd4:    val = ZW'(234379);
            5'd5:    val = ZW'(117304);
            5'd6:    val = ZW'(58666);
            5'd7:    val = ZW'(29335);
            5'd8:    val = ZW'(14668);
            5'd9:    val = ZW'(7334);
            5'd10:   val = ZW'(3667);
            5'd11:   val = ZW'(1833);
            5'd12:   val = ZW'(917);
            5'd13:   val = ZW'(458);
            5'd14:   val = ZW'(229);
            5'd15:   val = ZW'(115);
            5'd16:   val = ZW'(57);
            5'd17:   val = ZW'(29);
            5'd18:   val = ZW'(14);
            5'd19:   val = ZW'(7);
            5'd20:   val = ZW'(4);
            5'd21:   val = ZW'(2);
            5'd22:   val = ZW'(1);
            default: val = '0;
         endcase
         return val;
      end
   endfunction

endpackage

`default_nettype wire

### hw/rtl/r2p_prep.sv
`timescale 1ns / 1ps
`default_nettype none

module r2p_prep (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            in_valid,
   output logic                                 in_ready,
   input  wire logic [r2p_pkg::DATA_WIDTH-1:0]  in_real,
   input  wire logic [r2p_pkg::DATA_WIDTH-1:0]  in_imag,
   output logic                                 out_valid,
   input  wire logic                            out_ready,
   output r2p_pkg::r2p_data_type                out_data
);
   import r2p_pkg::*;

   logic signed [DATA_WIDTH-1:0] re;
   logic signed [DATA_WIDTH-1:0] im;
   logic                         re_zero;
   logic                         im_zero;
   logic [DATA_WIDTH:0]          re_abs;
   logic [DATA_WIDTH:0]          im_abs;
   logic signed [XW-1:0]         re_x;
   logic signed [XW-1:0]         im_y;
   logic                         valid_ff;
   r2p_data_type                 data_ff;
   r2p_data_type                 data_in;

   assign re = $signed(in_real);
   assign im = $signed(in_imag);
   assign re_zero = (re == '0);
   assign im_zero = (im == '0);

   // Absolute values for the axis cases.
   assign re_abs = re[DATA_WIDTH-1] ? -{re[DATA_WIDTH-1], re} : {1'b0, re};
   assign im_abs = im[DATA_WIDTH-1] ? -{im[DATA_WIDTH-1], im} : {1'b0, im};

   // Scale both parts to Q16.
   assign re_x = $signed({{(XW-DATA_WIDTH-FRAC_BITS){re[DATA_WIDTH-1]}}, re,
                          {FRAC_BITS{1'b0}}});
   assign im_y = $signed({{(XW-DATA_WIDTH-FRAC_BITS){im[DATA_WIDTH-1]}}, im,
                          {FRAC_BITS{1'b0}}});

   // Axis detection and the half-turn for a negative real part.
   always_comb begin
      data_in.special  = re_zero || im_zero;
      data_in.spec_mag = im_zero ? OUT_W'(re_abs) : OUT_W'(im_abs);
      if (im_zero) begin
         data_in.spec_ang = re[DATA_WIDTH-1] ? OUT_W'(DEG180_Q7) : '0;
      end else if (im[DATA_WIDTH-1]) begin
         data_in.spec_ang = OUT_W'(-DEG90_Q7);
      end else begin
         data_in.spec_ang = OUT_W'(DEG90_Q7);
      end
      if (re[DATA_WIDTH-1]) begin
         data_in.x = -re_x;
         data_in.y = -im_y;
         data_in.z = im[DATA_WIDTH-1] ? ZW'(-DEG180_Q16) : ZW'(DEG180_Q16);
      end else begin
         data_in.x = re_x;
         data_in.y = im_y;
         data_in.z = '0;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   // Entry register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

### hw/rtl/r2p_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module r2p_cell (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [r2p_pkg::IDX_W-1:0]   step_index,
   input  wire logic                        in_valid,
   output logic                             in_ready,
   input  wire r2p_pkg::r2p_data_type       in_data,
   output logic                             out_valid,
   input  wire logic                        out_ready,
   output r2p_pkg::r2p_data_type            out_data
);
   import r2p_pkg::*;

   logic signed [XW-1:0] xs;
   logic signed [XW-1:0] ys;
   logic signed [ZW-1:0] step_atan;
   logic                 valid_ff;
   r2p_data_type         data_ff;
   r2p_data_type         data_in;

   assign xs        = in_data.x >>> step_index;
   assign ys        = in_data.y >>> step_index;
   assign step_atan = atan_q16(step_index);

   // One micro-rotation toward the positive x axis.
   always_comb begin
      data_in = in_data;
      if (!in_data.y[XW-1]) begin
         data_in.x = in_data.x + ys;
         data_in.y = in_data.y - xs;
         data_in.z = in_data.z + step_atan;
      end else begin
         data_in.x = in_data.x - ys;
         data_in.y = in_data.y + xs;
         data_in.z = in_data.z - step_atan;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

### hw/rtl/r2p_post.sv
`timescale 1ns / 1ps
`default_nettype none

module r2p_post (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   output logic                            in_ready,
   input  wire r2p_pkg::r2p_data_type      in_data,
   output logic                            out_valid,
   input  wire logic                       out_ready,
   output logic [r2p_pkg::OUT_W-1:0]       out_magnitude,
   output logic [r2p_pkg::OUT_W-1:0]       out_angle
);
   import r2p_pkg::*;

   localparam int MAG_W = PH_W + 1 - GAIN_W;

   logic [XW-FRAC_BITS-1:0]     x_hi;
   logic [FRAC_BITS-1:0]        x_lo;
   logic [PH_W-1:0]             p_hi;
   logic [FRAC_BITS+GAIN_W-1:0] p_lo_full;
   logic                        mul_ready;
   logic                        res_ready;
   logic                        mul_valid_ff;
   logic [PH_W-1:0]             p_hi_ff;
   logic [GAIN_W-1:0]           p_lo_ff;
   logic signed [ZW-1:0]        z_ff;
   logic                        special_ff;
   logic [OUT_W-1:0]            spec_mag_ff;
   logic [OUT_W-1:0]            spec_ang_ff;
   logic [PH_W:0]               prod_sum;
   logic [MAG_W-1:0]            mag_wide;
   logic signed [ZW:0]          z_round;
   logic signed [ZW:0]          ang_wide;
   logic signed [ZW:0]          ang_clamp;
   logic                        res_valid_ff;
   logic [OUT_W-1:0]            mag_ff;
   logic [OUT_W-1:0]            mag_in;
   logic [OUT_W-1:0]            ang_ff;
   logic [OUT_W-1:0]            ang_in;

   // Gain correction, split into high and low partial products.
   assign x_hi      = in_data.x[XW-1:FRAC_BITS];
   assign x_lo      = in_data.x[FRAC_BITS-1:0];
   assign p_hi      = PH_W'(x_hi) * PH_W'(GAIN_Q30);
   assign p_lo_full = (FRAC_BITS+GAIN_W)'(x_lo) * (FRAC_BITS+GAIN_W)'(GAIN_Q30);

   // The output register takes a new value when it is empty or being read.
   assign res_ready = !res_valid_ff || out_ready;
   assign mul_ready = !mul_valid_ff || res_ready;
   assign in_ready  = mul_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (mul_ready) begin
         mul_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_ready) begin
         p_hi_ff     <= p_hi;
         p_lo_ff     <= p_lo_full[FRAC_BITS+GAIN_W-1:FRAC_BITS];
         z_ff        <= in_data.z;
         special_ff  <= in_data.special;
         spec_mag_ff <= in_data.spec_mag;
         spec_ang_ff <= in_data.spec_ang;
      end
   end

   // Sum the partial products, round half up and saturate.
   assign prod_sum = (PH_W+1)'(p_hi_ff) + (PH_W+1)'(p_lo_ff)
                   + (PH_W+1)'(1 << (GAIN_W - 1));
   assign mag_wide = prod_sum[PH_W:GAIN_W];

   // Degrees from Q16 to Q7 with rounding, then clamp to a half turn.
   assign z_round  = $signed({z_ff[ZW-1], z_ff}) + $signed((ZW+1)'(ANG_ROUND));
   assign ang_wide = z_round >>> ANG_SHIFT;

   always_comb begin
      if (ang_wide > $signed((ZW+1)'(DEG180_Q7))) begin
         ang_clamp = $signed((ZW+1)'(DEG180_Q7));
      end else if (ang_wide < $signed((ZW+1)'(-DEG180_Q7))) begin
         ang_clamp = $signed((ZW+1)'(-DEG180_Q7));
      end else begin
         ang_clamp = ang_wide;
      end
   end

   // Axis cases bypass the rotation result.
   always_comb begin
      if (special_ff) begin
         mag_in = spec_mag_ff;
         ang_in = spec_ang_ff;
      end else begin
         mag_in = (|mag_wide[MAG_W-1:OUT_W]) ? '1 : mag_wide[OUT_W-1:0];
         ang_in = ang_clamp[OUT_W-1:0];
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else if (res_ready) begin
         res_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready) begin
         mag_ff <= mag_in;
         ang_ff <= ang_in;
      end
   end

   assign out_valid     = res_valid_ff;
   assign out_magnitude = mag_ff;
   assign out_angle     = ang_ff;

endmodule

`default_nettype wire

### hw/rtl/rect_to_polar_degrees.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel    Direction  Ports
// request    in         req_valid, req_stall, req_real_part, req_imag_part
// result     out        rsp_valid, rsp_stall, rsp_magnitude, rsp_angle_deg
//
// One request per clock is accepted while the result side flows; each result passes
// through one entry register, 16 rotation cells and two gain and rounding stages.
// The pipeline takes a new request every cycle while the result side flows.
// Reset is synchronous and active high and empties every stage.
// A stall on the result side holds only the stages that are full; empty
// stages still fill, so the request side stalls only when all are occupied.

module rect_to_polar_degrees (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [r2p_pkg::DATA_WIDTH-1:0]  req_real_part,
   input  wire logic [r2p_pkg::DATA_WIDTH-1:0]  req_imag_part,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [r2p_pkg::OUT_W-1:0]            rsp_magnitude,
   output logic [r2p_pkg::OUT_W-1:0]            rsp_angle_deg
);
   import r2p_pkg::*;

`include "rect_to_polar_degrees_assert.svh"

   r2p_data_type chain_data  [ITERATIONS+1];
   logic         chain_valid [ITERATIONS+1];
   logic         chain_ready [ITERATIONS+1];
   logic         req_ready;

   // Entry stage: scaling, axis detection and the half-turn.
   r2p_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_real   (req_real_part),
      .in_imag   (req_imag_part),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   assign req_stall = !req_ready;

   // Row of rotation cells, one shift amount each.
   genvar k;
   generate
      for (k = 0; k < ITERATIONS; k++) begin : g_cell
         r2p_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .step_index (IDX_W'(k)),
            .in_valid   (chain_valid[k]),
            .in_ready   (chain_ready[k]),
            .in_data    (chain_data[k]),
            .out_valid  (chain_valid[k+1]),
            .out_ready  (chain_ready[k+1]),
            .out_data   (chain_data[k+1])
         );
      end
   endgenerate

   // Gain correction, rounding and the output register.
   r2p_post u_post (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (chain_valid[ITERATIONS]),
      .in_ready      (chain_ready[ITERATIONS]),
      .in_data       (chain_data[ITERATIONS]),
      .out_valid     (rsp_valid),
      .out_ready     (!rsp_stall),
      .out_magnitude (rsp_magnitude),
      .out_angle     (rsp_angle_deg)
   );

   // The angle never leaves the half-turn range.
   `RTPD_ASSERT_IMPL(a_angle_range, clock, reset, rsp_valid,
      ($signed(rsp_angle_deg) <= $signed(OUT_W'(DEG180_Q7)) &&
       $signed(rsp_angle_deg) >= $signed(OUT_W'(-DEG180_Q7))))

   // After all rotations a regular request has a positive x.
   `RTPD_ASSERT_IMPL(a_x_positive, clock, reset,
      (chain_valid[ITERATIONS] && !chain_data[ITERATIONS].special),
      (!chain_data[ITERATIONS].x[XW-1]))

   // An empty entry register always takes a request.
   `RTPD_ASSERT_IMPL(a_entry_free, clock, reset, !chain_valid[0], !req_stall)

   // A stalled result stays valid and keeps its value.
   `RTPD_ASSERT_NEXT(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall),
      (rsp_valid && $stable(rsp_magnitude) && $stable(rsp_angle_deg)))

endmodule

`default_nettype wire
